// ===== rtl/drfs_pkg.sv =====
// Shared types, constants and state codes for the decal ripple fade/scale block.
// No dependencies; the multiplier, divider, top block and testbench import this package.
`timescale 1ns / 1ps

package drfs_pkg;

   // default fraction bits of the time format
   localparam int TIME_FRAC_BITS_DEF = 16;

   // shared multiplier: signed operands wide enough for 32-bit unsigned values
   localparam int MUL_W  = 33;
   localparam int PROD_W = 2 * MUL_W;

   // divisor width: age * rate (56 bits) plus one in the scale format
   localparam int DEN_W = 57;

   localparam int CSR_ADDR_W = 8;

   localparam logic [CSR_ADDR_W-1:0] CSR_RAMP_TIME   = 8'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_DECAY_START = 8'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_LIFETIME    = 8'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_OUTPUT_MODE = 8'd3;

   localparam logic [1:0] OMODE_ARGB  = 2'd0;
   localparam logic [1:0] OMODE_ALPHA = 2'd1;
   localparam logic [1:0] OMODE_OPAC  = 2'd2;

   localparam logic MODE_BEGIN  = 1'b0;
   localparam logic MODE_VERTEX = 1'b1;

   localparam logic [15:0] ONE_Q15      = 16'h8000;
   localparam logic [23:0] HALF_Q16     = 24'h008000;
   localparam logic [14:0] GREY_MUL     = 15'd25599;  // 255.99 scaled by 100
   localparam logic [12:0] RECIP_100    = 13'd5243;   // 2^19 / 100, rounded up
   localparam logic [6:0]  DIV_100      = 7'd100;
   localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;
   localparam logic [7:0]  GREY_MAX     = 8'hFF;

   localparam logic [31:0] LIFETIME_RST = 32'h0001_0000;

   typedef struct packed {
      logic               mode;
      logic [31:0]        now_time;
      logic [31:0]        birth_time;
      logic [15:0]        init_atten;
      logic [23:0]        shrink_u_base;
      logic [23:0]        shrink_u_rate;
      logic [23:0]        shrink_v_base;
      logic [23:0]        shrink_v_rate;
      logic [15:0]        vertex_count;
      logic signed [23:0] orig_u;
      logic signed [23:0] orig_v;
      logic [15:0]        orig_opacity;
   } drfs_req_type;

   typedef struct packed {
      logic               expired;
      logic [31:0]        diffuse_word;
      logic [7:0]         alpha_byte;
      logic signed [23:0] tex_u;
      logic signed [23:0] tex_v;
      logic [15:0]        second_opacity;
   } drfs_rsp_type;

   typedef struct packed {
      logic [CSR_ADDR_W-1:0] addr;
      logic [31:0]           wdata;
   } drfs_csr_type;

   typedef struct packed {
      logic start;
   } drfs_div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } drfs_div_stat_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_CHECK,
      ST_ENV_MUL,
      ST_ENV_DIV,
      ST_ENV_WAIT,
      ST_U_MUL,
      ST_U_DIV,
      ST_U_WAIT,
      ST_V_MUL,
      ST_V_DIV,
      ST_V_WAIT,
      ST_VX_U,
      ST_VX_V,
      ST_VX_P,
      ST_VX_G,
      ST_VX_Y,
      ST_VX_Q,
      ST_VX_FIN,
      ST_OUT
   } drfs_state_type;

endpackage

// ===== rtl/drfs_chan_if.sv =====
// Valid/ready channel carrying one payload word of a given packed type.
// Used for the request, response and register-write channels; no dependencies.
`timescale 1ns / 1ps

interface drfs_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/drfs_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on drfs_pkg for operand widths.
`timescale 1ns / 1ps

module drfs_mul (
   input  logic                                clock,
   input  logic signed [drfs_pkg::MUL_W-1:0]   op_a,
   input  logic signed [drfs_pkg::MUL_W-1:0]   op_b,
   output logic signed [drfs_pkg::PROD_W-1:0]  prod_ff
);
   import drfs_pkg::*;

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(op_a) * PROD_W'(op_b);
   end

endmodule

// ===== rtl/drfs_div.sv =====
// Restoring divider, one quotient bit per cycle over the whole dividend.
// Depends on drfs_pkg for the control and status structs.
`timescale 1ns / 1ps

module drfs_div #(
   parameter int NUM_W = 56,
   parameter int DEN_W = 57
) (
   input  logic                          clock,
   input  logic                          reset,
   input  drfs_pkg::drfs_div_ctl_type    ctl,
   input  logic [NUM_W-1:0]              num,
   input  logic [DEN_W-1:0]              den,
   output drfs_pkg::drfs_div_stat_type   stat,
   output logic [NUM_W-1:0]              quot
);
   import drfs_pkg::*;

   localparam int CNT_W = $clog2(NUM_W);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [NUM_W-1:0] nq_ff;    // dividend bits shift out, quotient bits shift in
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;

   logic [DEN_W:0]   rem_shift;
   logic             qbit;
   logic [DEN_W:0]   rem_sub;

   assign rem_shift = {rem_ff, nq_ff[NUM_W-1]};
   assign qbit      = rem_shift >= {1'b0, den_ff};
   assign rem_sub   = rem_shift - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (ctl.start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == CNT_W'(NUM_W - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         cnt_ff <= '0;
         nq_ff  <= num;
         rem_ff <= '0;
         den_ff <= den;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + CNT_W'(1);
         nq_ff  <= {nq_ff[NUM_W-2:0], qbit};
         rem_ff <= qbit ? rem_sub[DEN_W-1:0] : rem_shift[DEN_W-1:0];
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quot      = nq_ff;

endmodule

// ===== rtl/decal_ripple_fade_scale.sv =====
// Decal ripple fader and UV shrinker: sequencer around one shared multiplier
// and one shared restoring divider. Depends on drfs_pkg, drfs_chan_if,
// drfs_mul and drfs_div.
`timescale 1ns / 1ps

// Accept to response handshake: an expired begin word goes straight to the output;
// a live begin word on the ramp or decay slope waits on three passes of the
// bit-serial divider (envelope, U scale, V scale); a live begin word in the hold
// span waits on the U and V scale passes only; a vertex word is set by six
// back-to-back uses of the shared multiplier.
// One word in flight; the next request is taken once the result is parked.
// Synchronous active-high reset: registers to their reset values, state zeroed.

module decal_ripple_fade_scale #(
   parameter int TIME_FRAC_BITS = drfs_pkg::TIME_FRAC_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   drfs_chan_if.sink   req_bus,
   drfs_chan_if.source rsp_bus,
   drfs_chan_if.sink   csr_bus
);
   import drfs_pkg::*;

   // scale dividend is base << (TIME_FRAC_BITS + 16)
   localparam int SCL_SH = TIME_FRAC_BITS + 16;
   localparam int NUM_W  = 24 + SCL_SH;
   localparam logic [DEN_W-1:0] SCALE_ONE = DEN_W'(1) << SCL_SH;

   // ---------------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------------
   logic [31:0] ramp_time_ff;
   logic [31:0] decay_start_ff;
   logic [31:0] lifetime_ff;
   logic [1:0]  output_mode_ff;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ramp_time_ff   <= '0;
         decay_start_ff <= '0;
         lifetime_ff    <= LIFETIME_RST;
         output_mode_ff <= OMODE_OPAC;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.data.addr)
            CSR_RAMP_TIME:   ramp_time_ff   <= csr_bus.data.wdata;
            CSR_DECAY_START: decay_start_ff <= csr_bus.data.wdata;
            CSR_LIFETIME:    lifetime_ff    <= csr_bus.data.wdata;
            CSR_OUTPUT_MODE: output_mode_ff <= csr_bus.data.wdata[1:0];
            default: ;  // unmapped index, ignored
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // sequencer state, decal state, working registers
   // ---------------------------------------------------------------------
   drfs_state_type state_ff, state_in;

   drfs_req_type req_ff;        // latched request word
   logic [31:0]  age_ff;        // clamped age, begin words
   logic [15:0]  init_ff;       // saturated initial attenuation

   logic [15:0]  atten_ff;      // decal state
   logic [23:0]  scale_u_ff;
   logic [23:0]  scale_v_ff;

   logic [30:0]  p_ff;          // opacity * attenuation
   logic [15:0]  y_ff;          // grey numerator before the /100 step
   logic [9:0]   q0_ff;         // reciprocal estimate of y / 100

   drfs_rsp_type res_work_ff;   // result being assembled
   drfs_rsp_type rsp_data_ff;   // output register
   logic         rsp_valid_ff;

   logic         req_take;
   logic         out_free;

   // shared units
   logic signed [MUL_W-1:0]  mul_a;
   logic signed [MUL_W-1:0]  mul_b;
   logic signed [PROD_W-1:0] prod_ff;
   drfs_div_ctl_type         div_ctl;
   drfs_div_stat_type        div_stat;
   logic [NUM_W-1:0]         div_num;
   logic [DEN_W-1:0]         div_den;
   logic [NUM_W-1:0]         div_quot;

   drfs_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (prod_ff)
   );

   drfs_div #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .ctl   (div_ctl),
      .num   (div_num),
      .den   (div_den),
      .stat  (div_stat),
      .quot  (div_quot)
   );

   // envelope decisions; the user must keep config static while a word is in flight, the block does not enforce it
   logic expire_now;
   logic env_ramp;
   logic env_decay;

   assign expire_now = (age_ff >= lifetime_ff) || (req_ff.vertex_count == 16'd0);
   assign env_ramp   = age_ff < ramp_time_ff;
   assign env_decay  = !env_ramp && (age_ff > decay_start_ff);

   // UV offsets about 0.5
   logic signed [24:0] du;
   logic signed [24:0] dv;
   assign du = 25'(req_ff.orig_u) - 25'sd32768;
   assign dv = 25'(req_ff.orig_v) - 25'sd32768;

   assign req_take = req_bus.valid && req_bus.ready;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   // ---------------------------------------------------------------------
   // next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:
            if (req_take) begin
               state_in = (req_bus.data.mode == MODE_VERTEX) ? ST_VX_U : ST_CHECK;
            end
         ST_CHECK:
            if (expire_now) begin
               state_in = ST_OUT;
            end else if (env_ramp || env_decay) begin
               state_in = ST_ENV_MUL;
            end else begin
               state_in = ST_U_MUL;
            end
         ST_ENV_MUL:  state_in = ST_ENV_DIV;
         ST_ENV_DIV:  state_in = ST_ENV_WAIT;
         ST_ENV_WAIT: if (div_stat.done) state_in = ST_U_MUL;
         ST_U_MUL:    state_in = ST_U_DIV;
         ST_U_DIV:    state_in = ST_U_WAIT;
         ST_U_WAIT:   if (div_stat.done) state_in = ST_V_MUL;
         ST_V_MUL:    state_in = ST_V_DIV;
         ST_V_DIV:    state_in = ST_V_WAIT;
         ST_V_WAIT:   if (div_stat.done) state_in = ST_OUT;
         ST_VX_U:     state_in = ST_VX_V;
         ST_VX_V:     state_in = ST_VX_P;
         ST_VX_P:     state_in = ST_VX_G;
         ST_VX_G:     state_in = ST_VX_Y;
         ST_VX_Y:     state_in = ST_VX_Q;
         ST_VX_Q:     state_in = ST_VX_FIN;
         ST_VX_FIN:   state_in = ST_OUT;
         ST_OUT:      if (out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------------------------------------------------------------
   // sequencer outputs: handshake, multiplier operands, divider start
   // ---------------------------------------------------------------------
   always_comb begin
      req_bus.ready = 1'b0;
      mul_a         = '0;
      mul_b         = '0;
      div_ctl.start = 1'b0;
      div_num       = '0;
      div_den       = '0;
      unique case (state_ff)
         ST_IDLE: req_bus.ready = 1'b1;
         ST_ENV_MUL: begin
            mul_a = MUL_W'($signed({1'b0, init_ff}));
            mul_b = env_ramp ? MUL_W'($signed({1'b0, age_ff}))
                             : MUL_W'($signed({1'b0, lifetime_ff - age_ff}));
         end
         ST_ENV_DIV: begin
            div_ctl.start = 1'b1;
            div_num       = NUM_W'(prod_ff[47:0]);
            div_den       = env_ramp ? DEN_W'(ramp_time_ff)
                                     : DEN_W'(lifetime_ff - decay_start_ff);
         end
         ST_U_MUL: begin
            mul_a = MUL_W'($signed({1'b0, age_ff}));
            mul_b = MUL_W'($signed({1'b0, req_ff.shrink_u_rate}));
         end
         ST_U_DIV: begin
            div_ctl.start = 1'b1;
            div_num       = {req_ff.shrink_u_base, SCL_SH'(0)};
            div_den       = {1'b0, prod_ff[55:0]} + SCALE_ONE;
         end
         ST_V_MUL: begin
            mul_a = MUL_W'($signed({1'b0, age_ff}));
            mul_b = MUL_W'($signed({1'b0, req_ff.shrink_v_rate}));
         end
         ST_V_DIV: begin
            div_ctl.start = 1'b1;
            div_num       = {req_ff.shrink_v_base, SCL_SH'(0)};
            div_den       = {1'b0, prod_ff[55:0]} + SCALE_ONE;
         end
         ST_VX_U: begin
            mul_a = MUL_W'(du);
            mul_b = MUL_W'($signed({1'b0, scale_u_ff}));
         end
         ST_VX_V: begin
            mul_a = MUL_W'(dv);
            mul_b = MUL_W'($signed({1'b0, scale_v_ff}));
         end
         ST_VX_P: begin
            mul_a = MUL_W'($signed({1'b0, req_ff.orig_opacity}));
            mul_b = MUL_W'($signed({1'b0, atten_ff}));
         end
         ST_VX_G: begin
            // product register holds p
            mul_a = MUL_W'($signed({1'b0, prod_ff[30:0]}));
            mul_b = MUL_W'($signed({1'b0, GREY_MUL}));
         end
         ST_VX_Y: begin
            // y = p * 25599 >> 30, then estimate y / 100
            mul_a = MUL_W'($signed({1'b0, prod_ff[45:30]}));
            mul_b = MUL_W'($signed({1'b0, RECIP_100}));
         end
         ST_VX_Q: begin
            mul_a = MUL_W'($signed({1'b0, prod_ff[28:19]}));
            mul_b = MUL_W'($signed({1'b0, DIV_100}));
         end
         default: ;
      endcase
   end

   // ---------------------------------------------------------------------
   // datapath
   // ---------------------------------------------------------------------
   // floor shift by 16, recenter, saturate to 24-bit signed
   function automatic logic [23:0] map_uv(input logic signed [PROD_W-1:0] p);
      logic signed [33:0] r;
      r = 34'($signed(p[48:16])) + 34'sd32768;
      if (r > 34'sd8388607) begin
         return 24'h7FFFFF;
      end else if (r < -34'sd8388608) begin
         return 24'h800000;
      end
      return r[23:0];
   endfunction

   logic [9:0]  grey_q;
   logic [7:0]  grey;
   logic [15:0] opac_s;

   always_comb begin
      // reciprocal estimate may overshoot by one
      grey_q = (prod_ff[16:0] > {1'b0, y_ff}) ? q0_ff - 10'd1 : q0_ff;
      grey   = (grey_q > 10'(GREY_MAX)) ? GREY_MAX : grey_q[7:0];
      opac_s = (p_ff[30:15] > ONE_Q15) ? ONE_Q15 : p_ff[30:15];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         atten_ff   <= '0;
         scale_u_ff <= '0;
         scale_v_ff <= '0;
      end else begin
         unique case (state_ff)
            ST_CHECK:
               if (!expire_now && !env_ramp && !env_decay) atten_ff <= init_ff;
            ST_ENV_WAIT: if (div_stat.done) atten_ff   <= div_quot[15:0];
            ST_U_WAIT:   if (div_stat.done) scale_u_ff <= div_quot[23:0];
            ST_V_WAIT:   if (div_stat.done) scale_v_ff <= div_quot[23:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_take) begin
         req_ff  <= req_bus.data;
         age_ff  <= (req_bus.data.now_time > req_bus.data.birth_time)
                    ? req_bus.data.now_time - req_bus.data.birth_time : 32'd0;
         init_ff <= (req_bus.data.init_atten > ONE_Q15) ? ONE_Q15
                                                       : req_bus.data.init_atten;
      end
      unique case (state_ff)
         ST_CHECK:
            if (expire_now) begin
               res_work_ff <= '{expired: 1'b1, default: '0};
            end
         ST_V_WAIT: if (div_stat.done) res_work_ff <= '0;
         ST_VX_V:   res_work_ff.tex_u <= map_uv(prod_ff);
         ST_VX_P:   res_work_ff.tex_v <= map_uv(prod_ff);
         ST_VX_G:   p_ff  <= prod_ff[30:0];
         ST_VX_Y:   y_ff  <= prod_ff[45:30];
         ST_VX_Q:   q0_ff <= prod_ff[28:19];
         ST_VX_FIN: begin
            res_work_ff.expired        <= 1'b0;
            res_work_ff.diffuse_word   <= (output_mode_ff == OMODE_ARGB)
                                          ? {ALPHA_OPAQUE, grey, grey, grey} : 32'd0;
            res_work_ff.alpha_byte     <= (output_mode_ff == OMODE_ALPHA) ? grey : 8'd0;
            // modes 2 and 3 carry the second-channel opacity
            res_work_ff.second_opacity <= (output_mode_ff == OMODE_ARGB ||
                                           output_mode_ff == OMODE_ALPHA) ? 16'd0 : opac_s;
         end
         default: ;
      endcase
   end

   // output register: parks a finished word while the next request is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_OUT && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT && out_free) begin
         rsp_data_ff <= res_work_ff;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.data  = rsp_data_ff;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   a_div_idle_on_start: assert property (@(posedge clock) disable iff (reset)
      div_ctl.start |-> !div_stat.busy)
      else $error("divider restarted while busy");

   a_leave_idle: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff != ST_IDLE)
      else $error("request taken but sequencer stayed idle");

   a_atten_range: assert property (@(posedge clock) disable iff (reset)
      atten_ff <= ONE_Q15)
      else $error("attenuation above unity");

   a_expired_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.expired |->
         rsp_data_ff.tex_u == 24'sd0 && rsp_data_ff.tex_v == 24'sd0 &&
         rsp_data_ff.diffuse_word == 32'd0 && rsp_data_ff.second_opacity == 16'd0)
      else $error("expired word carries data");

   a_opac_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff.second_opacity <= ONE_Q15)
      else $error("second opacity above unity");

endmodule

// ===== bench/tb_decal_ripple_fade_scale.sv =====
// Testbench for decal_ripple_fade_scale: directed and random words, with a scoreboard
// class that predicts every response. Depends on drfs_pkg, drfs_chan_if and the block.
`timescale 1ns / 1ps

module tb_decal_ripple_fade_scale;
   import drfs_pkg::*;

   // Holds the predicted decal state and the queue of expected response words.
   class decal_scoreboard;
      logic [31:0] ramp_q, decay_q, life_q;
      logic [1:0]  omode_q;
      logic [15:0] atten_q;
      logic [23:0] su_q, sv_q;
      drfs_rsp_type pending[$];
      int errors;

      function void clear();
         ramp_q = 0; decay_q = 0; life_q = LIFETIME_RST; omode_q = OMODE_OPAC;
         atten_q = 0; su_q = 0; sv_q = 0; errors = 0;
         pending.delete();
      endfunction

      function void write_reg(logic [CSR_ADDR_W-1:0] a, logic [31:0] d);
         case (a)
            CSR_RAMP_TIME:   ramp_q = d;
            CSR_DECAY_START: decay_q = d;
            CSR_LIFETIME:    life_q = d;
            CSR_OUTPUT_MODE: omode_q = d[1:0];
            default: ;
         endcase
      endfunction

      function logic [23:0] shrink(logic [23:0] base, logic [23:0] rate, logic [63:0] age);
         logic [127:0] den, num;
         den = age * rate + (128'd1 << 32);
         num = {104'd0, base} << 32;
         return 24'(num / den);
      endfunction

      function logic [23:0] shift_uv(logic signed [23:0] orig, logic [23:0] sc);
         logic signed [63:0] d, r;
         d = 64'(orig) - 64'sd32768;
         r = (d * $signed({40'd0, sc})) >>> 16;   // arithmetic shift floors
         r = r + 64'sd32768;
         if (r > 64'sd8388607) r = 64'sd8388607;
         if (r < -64'sd8388608) r = -64'sd8388608;
         return r[23:0];
      endfunction

      function void note_request(drfs_req_type q);
         drfs_rsp_type e;
         logic [63:0] age, init, att, p, g, s;
         e = '0;
         if (q.mode == MODE_BEGIN) begin
            age = (q.now_time > q.birth_time) ? 64'(q.now_time - q.birth_time) : 64'd0;
            if (age >= 64'(life_q) || q.vertex_count == 0) e.expired = 1'b1;
            else begin
               init = q.init_atten;
               if (init > 32768) init = 32768;
               if (age < 64'(ramp_q)) att = init * age / ramp_q;
               else if (age > 64'(decay_q)) att = init * (life_q - age) / (life_q - decay_q);
               else att = init;
               atten_q = att[15:0];
               su_q = shrink(q.shrink_u_base, q.shrink_u_rate, age);
               sv_q = shrink(q.shrink_v_base, q.shrink_v_rate, age);
            end
         end else begin
            p = 64'(q.orig_opacity) * atten_q;
            e.tex_u = shift_uv(q.orig_u, su_q);
            e.tex_v = shift_uv(q.orig_v, sv_q);
            if (omode_q == OMODE_ARGB || omode_q == OMODE_ALPHA) begin
               g = (p * 25599) / (64'd100 << 30);
               if (g > 255) g = 255;
               if (omode_q == OMODE_ARGB)
                  e.diffuse_word = {ALPHA_OPAQUE, g[7:0], g[7:0], g[7:0]};
               else e.alpha_byte = g[7:0];
            end else begin
               s = p >> 15;
               if (s > 32768) s = 32768;
               e.second_opacity = s[15:0];
            end
         end
         pending.push_back(e);
      endfunction

      function void check_response(drfs_rsp_type a);
         drfs_rsp_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected word %h", $time, a);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.expired !== e.expired) begin
            $display("%0t: expired exp %h got %h", $time, e.expired, a.expired); errors++;
         end
         if (a.diffuse_word !== e.diffuse_word) begin
            $display("%0t: diffuse exp %h got %h", $time, e.diffuse_word, a.diffuse_word);
            errors++;
         end
         if (a.alpha_byte !== e.alpha_byte) begin
            $display("%0t: alpha exp %h got %h", $time, e.alpha_byte, a.alpha_byte); errors++;
         end
         if (a.tex_u !== e.tex_u) begin
            $display("%0t: tex_u exp %h got %h", $time, e.tex_u, a.tex_u); errors++;
         end
         if (a.tex_v !== e.tex_v) begin
            $display("%0t: tex_v exp %h got %h", $time, e.tex_v, a.tex_v); errors++;
         end
         if (a.second_opacity !== e.second_opacity) begin
            $display("%0t: opacity exp %h got %h", $time, e.second_opacity, a.second_opacity);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   drfs_chan_if #(.payload_type(drfs_req_type)) req_bus ();
   drfs_chan_if #(.payload_type(drfs_rsp_type)) rsp_bus ();
   drfs_chan_if #(.payload_type(drfs_csr_type)) csr_bus ();

   decal_ripple_fade_scale dut (
      .clock(clock), .reset(reset),
      .req_bus(req_bus), .rsp_bus(rsp_bus), .csr_bus(csr_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   decal_scoreboard board = new();
   int  cycles = 0;
   int  hold_off = 0;     // cycles the receiver still refuses words
   bit  random_ready = 0;

   initial begin
      req_bus.valid = 1'b0;
      req_bus.data  = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.data  = '0;
      board.clear();
   end

   // Run limit: generous enough for every word of the test plus receiver stalls.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 1500000) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Receiver: random ready, short gaps mostly, long hold-offs at random and on request.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) board.check_response(rsp_bus.data);
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_bus.ready <= 1'b0;
      end else if (random_ready) begin
         if ($urandom_range(0, 99) < 3) hold_off <= $urandom_range(20, 300);
         rsp_bus.ready <= ($urandom_range(0, 3) != 0);
      end else
         rsp_bus.ready <= 1'b1;
   end

   // Drops valid only when a gap follows, so back-to-back words keep it high.
   task automatic idle_cycles();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) n = 0;
      if (n > 0) begin
         req_bus.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic send_word(drfs_req_type q);
      req_bus.valid <= 1'b1;
      req_bus.data  <= q;
      do @(posedge clock); while (!req_bus.ready);
      board.note_request(q);
   endtask

   task automatic send_gapped(drfs_req_type q);
      send_word(q);
      if (random_ready) idle_cycles();
   endtask

   task automatic write_csr(logic [CSR_ADDR_W-1:0] a, logic [31:0] d);
      drfs_csr_type c;
      c.addr = a;
      c.wdata = d;
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= c;
      do @(posedge clock); while (!csr_bus.ready);
      board.write_reg(a, d);
   endtask

   // Block must be idle before a register write.
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic program_env(logic [31:0] r, logic [31:0] d, logic [31:0] l, logic [1:0] m);
      drain();
      write_csr(CSR_RAMP_TIME, r);
      write_csr(CSR_DECAY_START, d);
      write_csr(CSR_LIFETIME, l);
      write_csr(CSR_OUTPUT_MODE, m);
      csr_bus.valid <= 1'b0;
   endtask

   function automatic drfs_req_type begin_word(logic [31:0] now, logic [31:0] birth,
                                               logic [15:0] att, logic [15:0] vc);
      drfs_req_type q;
      q = '0;
      q.mode = MODE_BEGIN;
      q.now_time = now; q.birth_time = birth; q.init_atten = att; q.vertex_count = vc;
      q.shrink_u_base = 24'($urandom); q.shrink_u_rate = 24'($urandom);
      q.shrink_v_base = 24'($urandom); q.shrink_v_rate = 24'($urandom);
      return q;
   endfunction

   function automatic drfs_req_type vertex_word(logic [23:0] u, logic [23:0] v,
                                                logic [15:0] op);
      drfs_req_type q;
      q = '0;
      q.mode = MODE_VERTEX;
      q.orig_u = u; q.orig_v = v; q.orig_opacity = op;
      return q;
   endfunction

   // Random word with random junk in the unused fields too, so every bit toggles.
   function automatic drfs_req_type random_word(bit is_begin, logic [31:0] life);
      drfs_req_type q;
      logic [31:0] age;
      logic [319:0] junk;
      junk = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom};
      q = junk[$bits(drfs_req_type)-1:0];
      q.mode = is_begin ? MODE_BEGIN : MODE_VERTEX;
      if ($urandom_range(0, 3) != 0) q.init_atten = 16'($urandom_range(0, 32768));
      if ($urandom_range(0, 7) == 0) q.orig_opacity = 16'h8000;
      if ($urandom_range(0, 2) == 0) begin
         q.orig_u = 24'($urandom_range(0, 131072));
         q.orig_v = 24'($urandom_range(0, 131072));
      end
      if (is_begin) begin
         // mostly live decals: age kept below lifetime
         age = (life == 0) ? 0 : $urandom_range(0, life - 1);
         if ($urandom_range(0, 5) != 0) q.now_time = q.birth_time + age;
         if ($urandom_range(0, 15) == 0) q.vertex_count = 0;
         else if (q.vertex_count == 0) q.vertex_count = 1;
      end
      return q;
   endfunction

   initial begin
      int n;
      logic [31:0] r, d, l;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: vertex on reset state, then envelope edges and field extremes.
      send_word(vertex_word(24'h7FFFFF, 24'h800000, 16'h8000));
      program_env(32'd4096, 32'd40000, 32'd65536, OMODE_ARGB);
      send_word(begin_word(32'd100, 32'd200, 16'hFFFF, 16'd3));       // negative age
      send_word(vertex_word(24'h7FFFFF, 24'h800000, 16'h8000));
      send_word(begin_word(32'd2000, 32'd0, 16'h8000, 16'hFFFF));      // ramping
      send_word(vertex_word(24'h000000, 24'h010000, 16'hFFFF));
      send_word(begin_word(32'd20000, 32'd0, 16'd12345, 16'd1));       // hold
      send_word(vertex_word(24'h008000, 24'hFFFFFF, 16'h4000));
      send_word(begin_word(32'd60000, 32'd0, 16'h8000, 16'd1));        // decay
      send_word(vertex_word(24'h123456, 24'h876543, 16'h8000));
      send_word(begin_word(32'd65536, 32'd0, 16'h8000, 16'd1));        // age equals life
      send_word(begin_word(32'hFFFFFFFF, 32'd0, 16'h8000, 16'd1));
      send_word(begin_word(32'd10, 32'd0, 16'h8000, 16'd0));           // no vertices
      send_word(vertex_word(24'h7FFFFF, 24'h7FFFFF, 16'h8000));
      program_env(32'd0, 32'hFFFFFFFE, 32'hFFFFFFFF, OMODE_ALPHA);
      send_word(begin_word(32'hFFFFFFFE, 32'd0, 16'h8000, 16'd9));
      send_word(vertex_word(24'h800000, 24'h7FFFFF, 16'hFFFF));
      send_word(begin_word(32'd0, 32'd0, 16'h8000, 16'd9));
      send_word(vertex_word(24'h800000, 24'h7FFFFF, 16'hFFFF));
      program_env(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 2'd3);     // mode three
      send_word(begin_word(32'd77777, 32'd0, 16'h8000, 16'd9));
      send_word(vertex_word(24'h7FFFFF, 24'h000000, 16'h8000));

      // Long receiver hold-off while the sender keeps offering words.
      drain();
      hold_off <= 400;
      @(posedge clock);
      repeat (6) send_word(vertex_word(24'($urandom), 24'($urandom), 16'($urandom)));
      drain();

      random_ready = 1;
      for (int phase = 0; phase < 6; phase++) begin
         r = $urandom_range(0, 40000);
         d = r + $urandom_range(0, 40000);
         l = d + $urandom_range(1, 200000);
         if (phase == 5) begin r = 0; d = 0; l = 32'hFFFFFFFF; end
         program_env(r, d, l, 2'($urandom_range(0, 3)));
         n = 0;
         while (n < 155) begin
            send_gapped(random_word(1'b1, l));
            n++;
            repeat ($urandom_range(1, 8)) begin
               send_gapped(random_word(1'b0, l));
               n++;
            end
            if ($urandom_range(0, 9) == 0) send_gapped(random_word(1'b1, 32'hFFFFFFFF));
         end
         // sender pause until all outstanding words return
         req_bus.valid <= 1'b0;
         while (board.pending.size() != 0) @(posedge clock);
      end

      drain();
      repeat (200) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end
endmodule
